FILE: rtl/wosc_pkg.sv
// Shared types, constants and the quarter-wave sine table for the waveform oscillator.
// Used by every module of the block; it depends on nothing else.
package wosc_pkg;

  // Field widths of the registers and the stream ports.
  localparam int WAVE_BITS      = 3;
  localparam int AMP_BITS       = 16;
  localparam int RATE_BITS      = 18;
  localparam int FREQ_BITS      = 25;
  localparam int FREQ_FRAC_BITS = 8;
  localparam int CFG_INDEX_BITS = 3;
  localparam int CFG_DATA_BITS  = 25;
  localparam int SAMPLE_BITS    = 16;
  localparam int PHASE_BITS_DEF = 32;

  // Register indexes on the configuration port.
  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_WAVEFORM    = 3'd0,
    REG_AMPLITUDE   = 3'd1,
    REG_TICK_RATE   = 3'd2,
    REG_BASE_FREQ   = 3'd3,
    REG_FM_ENABLE   = 3'd4
  } cfg_reg_t;

  // Waveform codes; anything above the rectangle is rejected.
  localparam logic [WAVE_BITS-1:0] WAVE_SINE      = 3'd0;
  localparam logic [WAVE_BITS-1:0] WAVE_COSINE    = 3'd1;
  localparam logic [WAVE_BITS-1:0] WAVE_TRIANGLE  = 3'd2;
  localparam logic [WAVE_BITS-1:0] WAVE_SAW       = 3'd3;
  localparam logic [WAVE_BITS-1:0] WAVE_RECTANGLE = 3'd4;

  // Register values after reset.
  localparam logic [WAVE_BITS-1:0] RST_WAVEFORM    = WAVE_SINE;
  localparam logic [AMP_BITS-1:0]  RST_AMPLITUDE   = 16'd32768;
  localparam logic [RATE_BITS-1:0] RST_TICK_RATE   = 18'd48000;
  localparam logic [FREQ_BITS-1:0] RST_BASE_FREQ   = 25'd112640;
  localparam logic                 RST_FM_ENABLE   = 1'b0;

  // Waveform values are Q15 with plus one as 32768, so they need 17 signed bits.
  localparam int WAVE_VAL_BITS = 17;
  localparam logic signed [WAVE_VAL_BITS-1:0] WAVE_UNIT = 17'sd32768;
  localparam int OUT_SHIFT = 31 - SAMPLE_BITS;

  // Quarter-wave sine table: SINE_DEPTH + 1 entries, unsigned Q15.
  localparam int SINE_DEPTH     = 1024;
  localparam int SINE_IDX_BITS  = $clog2(SINE_DEPTH);
  localparam int SINE_ADDR_BITS = SINE_IDX_BITS + 1;
  localparam int SINE_VAL_BITS  = 16;
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  typedef logic [SINE_VAL_BITS-1:0] sine_rom_t [SINE_DEPTH+1];

  // Raises a Q30 term by two powers of x.
  function automatic logic [63:0] sq_step(input logic [63:0] term, input logic [63:0] x);
    logic [63:0] t;
    t = (term * x) >> 30;
    t = (t * x) >> 30;
    return t;
  endfunction

  // Builds the table at elaboration from a Taylor series of sin in Q30.
  function automatic sine_rom_t build_sine();
    sine_rom_t          tbl;
    logic [63:0]        x;
    logic [63:0]        term;
    logic signed [63:0] acc;
    logic [63:0]        scaled;
    for (int i = 0; i <= SINE_DEPTH; i++) begin
      x    = (HALF_PI_Q30 * 64'(i)) / SINE_DEPTH;
      term = x;
      acc  = signed'(x);
      term = sq_step(term, x) / 6;
      acc  = acc - signed'(term);
      term = sq_step(term, x) / 20;
      acc  = acc + signed'(term);
      term = sq_step(term, x) / 42;
      acc  = acc - signed'(term);
      term = sq_step(term, x) / 72;
      acc  = acc + signed'(term);
      term = sq_step(term, x) / 110;
      acc  = acc - signed'(term);
      term = sq_step(term, x) / 156;
      acc  = acc + signed'(term);
      term = sq_step(term, x) / 210;
      acc  = acc - signed'(term);
      term = sq_step(term, x) / 272;
      acc  = acc + signed'(term);
      if (acc < 0) begin
        acc = '0;
      end
      scaled = ((unsigned'(acc) * 64'd32768) + (64'd1 << 29)) >> 30;
      tbl[i] = scaled[SINE_VAL_BITS-1:0];
    end
    return tbl;
  endfunction

  localparam sine_rom_t SINE_ROM = build_sine();

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;
    logic look;
    logic mul;
    logic rnd;
    logic div_step;
    logic advance;
    logic push;
  } wosc_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic fault;
  } wosc_status_t;

endpackage

FILE: rtl/waveform_oscillator.sv
// Waveform oscillator, a phase-accumulator tone generator.
// Each accepted tick on the input channel yields one output sample.
//
// Channels: the input carries freq_in (used only with fm_enable set) on in_valid and
// in_ready; the output carries sample and error on out_valid and out_ready. A
// transfer happens at a rising edge with valid and ready both high. Registers are
// written through cfg_write, cfg_index and cfg_data; a write to a known register
// restarts the phase at zero.
// The input takes one tick at a time: a tick passes lookup, gain, rounding, the
// bit-serial divider that forms freq * 2^(PHASE_BITS-8) / tick rate, one quotient
// bit a cycle, the phase advance and the output register before the next is taken;
// a rejected tick skips the arithmetic and goes straight to the output register.
// The input is taken while an earlier sample still sits in the output register;
// when the receiver stalls, a finished sample waits until that register is free.
// Reset (synchronous, active high) restores the register defaults, clears the
// phase and empties the output register.
// Depends on wosc_pkg, wosc_ctrl and wosc_datapath.
module waveform_oscillator #(
  parameter int PHASE_BITS = wosc_pkg::PHASE_BITS_DEF
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    cfg_write,
  input  logic [wosc_pkg::CFG_INDEX_BITS-1:0]     cfg_index,
  input  logic [wosc_pkg::CFG_DATA_BITS-1:0]      cfg_data,
  input  logic                                    in_valid,
  output logic                                    in_ready,
  input  logic [wosc_pkg::FREQ_BITS-1:0]          freq_in,
  output logic                                    out_valid,
  input  logic                                    out_ready,
  output logic signed [wosc_pkg::SAMPLE_BITS-1:0] sample,
  output logic                                    error
);
  import wosc_pkg::*;

  wosc_cmd_t    cmd;
  wosc_status_t status;

  // Sequencing of one tick.
  wosc_ctrl #(
    .PHASE_BITS(PHASE_BITS)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .status   (status),
    .cmd      (cmd)
  );

  // Arithmetic, state and the output register.
  wosc_datapath #(
    .PHASE_BITS(PHASE_BITS)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .freq_in  (freq_in),
    .cmd      (cmd),
    .status   (status),
    .sample   (sample),
    .error    (error)
  );

endmodule

FILE: rtl/wosc_ctrl.sv
// Controller of the waveform oscillator: sequences lookup, scaling, the phase
// increment divider and the output register. Depends on wosc_pkg.
module wosc_ctrl #(
  parameter int PHASE_BITS = wosc_pkg::PHASE_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  output logic                  out_valid,
  input  logic                  out_ready,
  input  wosc_pkg::wosc_status_t status,
  output wosc_pkg::wosc_cmd_t    cmd
);
  import wosc_pkg::*;

  // One divider step per bit of freq * 2^(PHASE_BITS-8).
  localparam int DIV_STEPS = FREQ_BITS + PHASE_BITS - FREQ_FRAC_BITS;
  localparam int CNT_BITS  = $clog2(DIV_STEPS);

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOOK,
    S_MUL,
    S_RND,
    S_DIV,
    S_ADV,
    S_PUSH
  } state_t;

  state_t              state;
  logic [CNT_BITS-1:0] step_cnt;
  logic                take;
  logic                div_last;
  logic                push_ok;

  assign in_ready = (state == S_IDLE);
  assign take     = in_valid && in_ready;
  assign div_last = (step_cnt == CNT_BITS'(DIV_STEPS - 1));
  assign push_ok  = (state == S_PUSH) && (!out_valid || out_ready);

  // Datapath commands follow the state directly.
  always_comb begin
    cmd          = '0;
    cmd.accept   = take;
    cmd.look     = (state == S_LOOK);
    cmd.mul      = (state == S_MUL);
    cmd.rnd      = (state == S_RND);
    cmd.div_step = (state == S_DIV);
    cmd.advance  = (state == S_ADV);
    cmd.push     = push_ok;
  end

  // State, divider step count and output valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      step_cnt  <= '0;
      out_valid <= 1'b0;
    end else begin
      if (push_ok) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          step_cnt <= '0;
          if (take) begin
            state <= status.fault ? S_PUSH : S_LOOK;
          end
        end
        S_LOOK: begin
          state <= S_MUL;
        end
        S_MUL: begin
          state <= S_RND;
        end
        S_RND: begin
          state <= S_DIV;
        end
        S_DIV: begin
          step_cnt <= step_cnt + 1'b1;
          if (div_last) begin
            state <= S_ADV;
          end
        end
        S_ADV: begin
          state <= S_PUSH;
        end
        S_PUSH: begin
          if (push_ok) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: rtl/wosc_datapath.sv
// Datapath of the waveform oscillator: registers, phase accumulator, sine lookup,
// gain multiplier, rounding and a bit-serial divider. Depends on wosc_pkg.
module wosc_datapath #(
  parameter int PHASE_BITS = wosc_pkg::PHASE_BITS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   cfg_write,
  input  logic [wosc_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
  input  logic [wosc_pkg::CFG_DATA_BITS-1:0]     cfg_data,
  input  logic [wosc_pkg::FREQ_BITS-1:0]         freq_in,
  input  wosc_pkg::wosc_cmd_t                    cmd,
  output wosc_pkg::wosc_status_t                 status,
  output logic signed [wosc_pkg::SAMPLE_BITS-1:0] sample,
  output logic                                   error
);
  import wosc_pkg::*;

  localparam int QSHIFT    = PHASE_BITS - 2;
  localparam int PROD_BITS = 2 * WAVE_VAL_BITS;
  localparam logic signed [PROD_BITS-1:0] ROUND_BIAS = PROD_BITS'(1) << (OUT_SHIFT - 1);
  localparam logic signed [PROD_BITS-1:0] SAT_HI =
    PROD_BITS'((64'd1 << (SAMPLE_BITS - 1)) - 64'd1);
  localparam logic signed [PROD_BITS-1:0] SAT_LO = ~SAT_HI;

  // Configuration and phase state.
  logic [WAVE_BITS-1:0]  waveform;
  logic [AMP_BITS-1:0]   amplitude;
  logic [RATE_BITS-1:0]  tick_rate;
  logic [FREQ_BITS-1:0]  base_freq;
  logic                  fm_enable;
  logic [PHASE_BITS-1:0] phase_acc;

  // Per-item working registers.
  logic                            err_r;
  logic [SINE_VAL_BITS-1:0]        rom_q;
  logic                            rom_neg;
  logic signed [PROD_BITS-1:0]     prod_q;
  logic signed [SAMPLE_BITS-1:0]   sample_r;
  logic [FREQ_BITS-1:0]            num;
  logic [RATE_BITS-1:0]            rem;
  logic [PHASE_BITS-1:0]           quot;

  // Combinational helpers.
  logic [1:0]                      quad;
  logic [SINE_IDX_BITS-1:0]        fine_idx;
  logic [SINE_ADDR_BITS-1:0]       rom_addr;
  logic [15:0]                     f16;
  logic [WAVE_VAL_BITS-1:0]        tri_ramp;
  logic signed [WAVE_VAL_BITS-1:0] rom_s;
  logic signed [WAVE_VAL_BITS-1:0] wave_val;
  logic signed [PROD_BITS-1:0]     biased;
  logic signed [PROD_BITS-1:0]     shifted;
  logic [RATE_BITS:0]              trial;
  logic [RATE_BITS:0]              diff;
  logic                            ge;

  // A tick is rejected for a bad code, a zero rate or a zero fixed frequency.
  assign status.fault = (waveform > WAVE_RECTANGLE) || (tick_rate == '0) ||
                        (!fm_enable && (base_freq == '0));

  // Registers; any valid register write also restarts the phase.
  always_ff @(posedge clk) begin
    if (rst) begin
      waveform    <= RST_WAVEFORM;
      amplitude   <= RST_AMPLITUDE;
      tick_rate   <= RST_TICK_RATE;
      base_freq   <= RST_BASE_FREQ;
      fm_enable   <= RST_FM_ENABLE;
      phase_acc   <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_WAVEFORM: begin
          waveform  <= cfg_data[WAVE_BITS-1:0];
          phase_acc <= '0;
        end
        REG_AMPLITUDE: begin
          amplitude <= cfg_data[AMP_BITS-1:0];
          phase_acc <= '0;
        end
        REG_TICK_RATE: begin
          tick_rate <= cfg_data[RATE_BITS-1:0];
          phase_acc <= '0;
        end
        REG_BASE_FREQ: begin
          base_freq <= cfg_data[FREQ_BITS-1:0];
          phase_acc <= '0;
        end
        REG_FM_ENABLE: begin
          fm_enable <= cfg_data[0];
          phase_acc <= '0;
        end
        default: begin
        end
      endcase
    end else if (cmd.advance) begin
      phase_acc <= phase_acc + quot;
    end
  end

  // Quarter-wave address: cosine is the sine a quarter turn ahead, odd quadrants mirror.
  always_comb begin
    quad     = phase_acc[PHASE_BITS-1 -: 2] + ((waveform == WAVE_COSINE) ? 2'd1 : 2'd0);
    fine_idx = phase_acc[QSHIFT-1 -: SINE_IDX_BITS];
    rom_addr = quad[0] ? (SINE_ADDR_BITS'(SINE_DEPTH) - {1'b0, fine_idx})
                       : {1'b0, fine_idx};
  end

  // Waveform value from the top phase bits or the table output.
  always_comb begin
    f16      = phase_acc[PHASE_BITS-1 -: 16];
    tri_ramp = {1'b0, f16[14:0], 1'b0};
    rom_s    = signed'({1'b0, rom_q});
    case (waveform)
      WAVE_SINE, WAVE_COSINE: wave_val = rom_neg ? -rom_s : rom_s;
      WAVE_TRIANGLE: begin
        wave_val = f16[15] ? (WAVE_UNIT - signed'(tri_ramp)) : (signed'(tri_ramp) - WAVE_UNIT);
      end
      WAVE_SAW:       wave_val = signed'({1'b0, f16}) - WAVE_UNIT;
      WAVE_RECTANGLE: wave_val = f16[15] ? WAVE_UNIT : -WAVE_UNIT;
      default:        wave_val = '0;
    endcase
  end

  // Round half up, then drop the fraction bits.
  assign biased  = prod_q + ROUND_BIAS;
  assign shifted = biased >>> OUT_SHIFT;

  // One restoring division step: bring down a numerator bit, subtract if it fits.
  assign trial = {rem, num[FREQ_BITS-1]};
  assign diff  = trial - {1'b0, tick_rate};
  assign ge    = (trial >= {1'b0, tick_rate});

  // Working registers of one tick.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      err_r <= status.fault;
      num   <= fm_enable ? freq_in : base_freq;
      rem   <= '0;
      quot  <= '0;
    end
    if (cmd.look) begin
      rom_q   <= SINE_ROM[rom_addr];
      rom_neg <= quad[1];
    end
    if (cmd.mul) begin
      prod_q <= wave_val * signed'({1'b0, amplitude});
    end
    if (cmd.rnd) begin
      if (shifted > SAT_HI) begin
        sample_r <= SAT_HI[SAMPLE_BITS-1:0];
      end else if (shifted < SAT_LO) begin
        sample_r <= SAT_LO[SAMPLE_BITS-1:0];
      end else begin
        sample_r <= shifted[SAMPLE_BITS-1:0];
      end
    end
    if (cmd.div_step) begin
      num  <= {num[FREQ_BITS-2:0], 1'b0};
      rem  <= ge ? diff[RATE_BITS-1:0] : trial[RATE_BITS-1:0];
      quot <= {quot[PHASE_BITS-2:0], ge};
    end
  end

  // Output register; a rejected tick shows zero with the error flag.
  always_ff @(posedge clk) begin
    if (cmd.push) begin
      sample <= err_r ? '0 : sample_r;
      error  <= err_r;
    end
  end

endmodule

FILE: rtl/wosc_checker.sv
// Port-level checks for the waveform oscillator, bound to the top level.
// Depends on wosc_pkg and waveform_oscillator.
module wosc_checker (
  input logic                                    clk,
  input logic                                    rst,
  input logic                                    in_valid,
  input logic                                    in_ready,
  input logic                                    out_valid,
  input logic                                    out_ready,
  input logic signed [wosc_pkg::SAMPLE_BITS-1:0] sample,
  input logic                                    error
);
  import wosc_pkg::*;

  // A waiting sample holds until it is taken.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(sample) && $stable(error))
    else $error("stalled output changed");

  // A rejected tick always reads as zero.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && error |-> sample == '0)
    else $error("error sample is not zero");

  // Only one tick is worked on at a time.
  assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken twice in a row");

  // Reset empties the output register.
  assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind waveform_oscillator wosc_checker u_checker (.*);

FILE: tb/waveform_oscillator_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for the waveform oscillator: a scoreboard class keeps its own
// phase accumulator and quarter-wave sine table and predicts every sample and error flag.
// Depends on wosc_pkg and the waveform_oscillator RTL.

module waveform_oscillator_tb;
  import wosc_pkg::*;

  localparam int PHASE_W        = PHASE_BITS_DEF;
  localparam int Q15_ONE        = 32768;
  localparam longint SAMPLE_MAX = (longint'(1) << (SAMPLE_BITS - 1)) - 1;
  localparam longint SAMPLE_MIN = -(longint'(1) << (SAMPLE_BITS - 1));
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_TICKS   = 1250;
  localparam int SETTLE_CYCLES  = 80;
  localparam int MAX_REPORTS    = 30;
  localparam real HALF_PERIOD   = 4.0;

  // Register indexes that the block does not decode, and the highest waveform code.
  localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE_FIRST = 3'd5;
  localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE_LAST  = 3'd7;
  localparam logic [WAVE_BITS-1:0]      WAVE_CODE_LAST  = 3'd7;

  typedef struct {
    logic signed [SAMPLE_BITS-1:0] value;
    logic                          err;
  } tone_t;

  // Predicts each output sample and checks the transfers seen on the output channel.
  class tone_scoreboard;
    logic [WAVE_BITS-1:0] waveform;
    logic [AMP_BITS-1:0]  amplitude;
    logic [RATE_BITS-1:0] rate;
    logic [FREQ_BITS-1:0] base_freq;
    logic                 fm;
    logic [PHASE_W-1:0]   phase;
    int unsigned          quarter_sine [SINE_DEPTH+1];
    tone_t                tones_due [$];
    int                   errors;

    function new();
      longint unsigned x;
      longint unsigned term;
      longint          acc;
      waveform  = RST_WAVEFORM;
      amplitude = RST_AMPLITUDE;
      rate      = RST_TICK_RATE;
      base_freq = RST_BASE_FREQ;
      fm        = RST_FM_ENABLE;
      phase     = '0;
      errors    = 0;
      // Quarter-wave table from a Taylor series of sin in Q30, rounded to Q15.
      for (int i = 0; i <= SINE_DEPTH; i++) begin
        x    = (HALF_PI_Q30 * longint'(i)) / SINE_DEPTH;
        term = x;
        acc  = longint'(x);
        for (int k = 1; k <= 8; k++) begin
          term = (term * x) >> 30;
          term = (term * x) >> 30;
          term = term / longint'((2 * k) * (2 * k + 1));
          if (k % 2 == 1) begin
            acc -= longint'(term);
          end else begin
            acc += longint'(term);
          end
        end
        if (acc < 0) begin
          acc = 0;
        end
        quarter_sine[i] = int'((longint'(acc) * Q15_ONE + (longint'(1) << 29)) >> 30);
      end
    endfunction

    // A write to a decoded register also restarts the phase.
    function void set_reg(logic [CFG_INDEX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
      case (idx)
        REG_WAVEFORM:    waveform  = data[WAVE_BITS-1:0];
        REG_AMPLITUDE:   amplitude = data[AMP_BITS-1:0];
        REG_TICK_RATE:   rate      = data[RATE_BITS-1:0];
        REG_BASE_FREQ:   base_freq = data[FREQ_BITS-1:0];
        REG_FM_ENABLE:   fm        = data[0];
        default:         return;
      endcase
      phase = '0;
    endfunction

    function int sine_at(logic [PHASE_W-1:0] ph);
      logic [1:0]      quad;
      longint unsigned idx;
      int              v;
      quad = ph[PHASE_W-1 -: 2];
      idx  = (longint'(ph[PHASE_W-3:0]) * SINE_DEPTH) >> (PHASE_W - 2);
      if (idx > SINE_DEPTH) begin
        idx = SINE_DEPTH;
      end
      if (quad[0]) begin
        idx = SINE_DEPTH - idx;
      end
      v = int'(quarter_sine[idx]);
      return quad[1] ? -v : v;
    endfunction

    // Phase increment: floor(freq * 2^(PHASE_W-8) / rate), kept to the accumulator width.
    function logic [PHASE_W-1:0] phase_increment(logic [FREQ_BITS-1:0] freq);
      longint unsigned wide;
      wide = (longint'(freq) << (PHASE_W - FREQ_FRAC_BITS)) / rate;
      return wide[PHASE_W-1:0];
    endfunction

    // Works out the sample for one accepted tick and advances the phase.
    function void note_tick(logic [FREQ_BITS-1:0] freq_in);
      tone_t                t;
      logic [FREQ_BITS-1:0] freq;
      logic [15:0]          f16;
      int                   w;
      longint               p;
      longint               s;
      freq    = fm ? freq_in : base_freq;
      f16     = phase[PHASE_W-1 -: 16];
      t.value = '0;
      t.err   = 1'b1;
      if (waveform > WAVE_RECTANGLE || rate == 0 || (!fm && base_freq == 0)) begin
        tones_due.push_back(t);
        return;
      end
      case (waveform)
        WAVE_SINE:     w = sine_at(phase);
        WAVE_COSINE:   w = sine_at(phase + {2'b01, {(PHASE_W - 2){1'b0}}});
        WAVE_TRIANGLE: w = (f16 < Q15_ONE) ? 2 * int'(f16) - Q15_ONE
                                           : 3 * Q15_ONE - 2 * int'(f16);
        WAVE_SAW:      w = int'(f16) - Q15_ONE;
        default:       w = (f16 < Q15_ONE) ? -Q15_ONE : Q15_ONE;
      endcase
      // Scale, round half up and saturate to the sample width.
      p = longint'(w) * longint'(amplitude);
      s = (p + (longint'(1) << (OUT_SHIFT - 1))) >>> OUT_SHIFT;
      if (s > SAMPLE_MAX) begin
        s = SAMPLE_MAX;
      end
      if (s < SAMPLE_MIN) begin
        s = SAMPLE_MIN;
      end
      t.value = s[SAMPLE_BITS-1:0];
      t.err   = 1'b0;
      tones_due.push_back(t);
      phase = phase + phase_increment(freq);
    endfunction

    task report(string what);
      if (errors < MAX_REPORTS) begin
        $display("%0t mismatch: %s", $time, what);
      end
      errors++;
    endtask

    task check_tone(logic signed [SAMPLE_BITS-1:0] value, logic err);
      tone_t t;
      if (tones_due.size() == 0) begin
        report($sformatf("sample %0d error %0b arrived with nothing due", value, err));
        return;
      end
      t = tones_due.pop_front();
      if (value !== t.value) begin
        report($sformatf("sample %0d, predicted %0d", value, t.value));
      end
      if (err !== t.err) begin
        report($sformatf("error flag %0b, predicted %0b", err, t.err));
      end
    endtask

    function int pending();
      return tones_due.size();
    endfunction
  endclass

  logic                          clk       = 1'b0;
  logic                          rst       = 1'b1;
  logic                          cfg_write = 1'b0;
  logic [CFG_INDEX_BITS-1:0]     cfg_index = '0;
  logic [CFG_DATA_BITS-1:0]      cfg_data  = '0;
  logic                          in_valid  = 1'b0;
  logic                          in_ready;
  logic [FREQ_BITS-1:0]          freq_in   = '0;
  logic                          out_valid;
  logic                          out_ready = 1'b0;
  logic signed [SAMPLE_BITS-1:0] sample;
  logic                          error;

  bit             steady = 1'b0;
  int             quiet_cycles = 0;
  tone_scoreboard board;

  waveform_oscillator dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .freq_in   (freq_in),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sample    (sample),
    .error     (error)
  );

  always #(HALF_PERIOD) clk = ~clk;

  // Gap lengths: mostly none or short, now and then long.
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 16);
    return $urandom_range(17, 90);
  endfunction

  function automatic logic [FREQ_BITS-1:0] rand_freq();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2, 3:    return FREQ_BITS'($urandom_range(1, 20000 << FREQ_FRAC_BITS));
      default: return FREQ_BITS'($urandom_range(0, (1 << FREQ_BITS) - 1));
    endcase
  endfunction

  // Output side: ready in bursts with random stalls between them, always ready when steady.
  initial begin
    @(posedge clk);
    forever begin
      if (steady || $urandom_range(0, 2) != 0) begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 30)) @(posedge clk);
      end else begin
        out_ready <= 1'b0;
        repeat (1 + gap_len()) @(posedge clk);
      end
    end
  end

  // Result checking and the watchdog on cycles without any transfer.
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) begin
        board.check_tone(sample, error);
      end
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("waveform_oscillator_tb failed");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  task automatic write_reg(logic [CFG_INDEX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    board.set_reg(idx, data);
    cfg_write <= 1'b0;
    @(posedge clk);
  endtask

  // One tick on the input channel; valid stays high if the next tick follows at once.
  task automatic send_tick(logic [FREQ_BITS-1:0] freq);
    int gap;
    gap = steady ? 0 : gap_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    freq_in  <= freq;
    do @(posedge clk); while (!in_ready);
    board.note_tick(freq);
  endtask

  // Closes a phase: no more ticks, then wait until every sample has come back.
  task automatic drain();
    in_valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
  endtask

  task automatic send_ticks(int count, logic [FREQ_BITS-1:0] freq);
    for (int i = 0; i < count; i++) begin
      send_tick(freq);
    end
    drain();
  endtask

  // Random register settings: most registers rewritten about half the time, the modulation enable a third of the time.
  task automatic shuffle_config();
    logic [CFG_DATA_BITS-1:0] data;
    data = CFG_DATA_BITS'($urandom);
    if ($urandom_range(0, 1) == 0) begin
      data[WAVE_BITS-1:0] = ($urandom_range(0, 9) == 0) ?
          WAVE_BITS'($urandom_range(WAVE_RECTANGLE + 1, WAVE_CODE_LAST)) :
          WAVE_BITS'($urandom_range(WAVE_SINE, WAVE_RECTANGLE));
      write_reg(REG_WAVEFORM, data);
    end
    data = CFG_DATA_BITS'($urandom);
    if ($urandom_range(0, 1) == 0) begin
      case ($urandom_range(0, 5))
        0:       data[AMP_BITS-1:0] = '0;
        1:       data[AMP_BITS-1:0] = '1;
        default: ;
      endcase
      write_reg(REG_AMPLITUDE, data);
    end
    data = CFG_DATA_BITS'($urandom);
    if ($urandom_range(0, 1) == 0) begin
      case ($urandom_range(0, 39))
        0:       data[RATE_BITS-1:0] = '0;
        1, 2:    data[RATE_BITS-1:0] = RATE_BITS'(1);
        3, 4:    data[RATE_BITS-1:0] = '1;
        5, 6:    data[RATE_BITS-1:0] = RST_TICK_RATE;
        default: if (data[RATE_BITS-1:0] == 0) data[0] = 1'b1;
      endcase
      write_reg(REG_TICK_RATE, data);
    end
    data = rand_freq();
    if ($urandom_range(0, 1) == 0) begin
      if (data == 0 && $urandom_range(0, 1) == 0) begin
        data = RST_BASE_FREQ;
      end
      write_reg(REG_BASE_FREQ, data);
    end
    data = CFG_DATA_BITS'($urandom);
    if ($urandom_range(0, 2) == 0) begin
      write_reg(REG_FM_ENABLE, data);
    end
    if ($urandom_range(0, 9) == 0) begin
      write_reg(CFG_INDEX_BITS'($urandom_range(REG_SPARE_FIRST, REG_SPARE_LAST)),
                CFG_DATA_BITS'($urandom));
    end
  endtask

  initial begin
    int sent;
    int n;
    board = new();
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part: register defaults first.
    send_ticks(3, '0);
    // Cosine at full gain saturates at the top; upper data bits must be dropped.
    write_reg(REG_WAVEFORM, {22'h3FFFFF, WAVE_COSINE});
    write_reg(REG_AMPLITUDE, '1);
    send_ticks(2, '0);
    // Triangle with the largest frequency at the lowest rate: the increment wraps.
    write_reg(REG_WAVEFORM, CFG_DATA_BITS'(WAVE_TRIANGLE));
    write_reg(REG_BASE_FREQ, '1);
    write_reg(REG_TICK_RATE, CFG_DATA_BITS'(1));
    send_ticks(2, '0);
    // Saw with the slowest possible tone.
    write_reg(REG_WAVEFORM, CFG_DATA_BITS'(WAVE_SAW));
    write_reg(REG_TICK_RATE, CFG_DATA_BITS'({RATE_BITS{1'b1}}));
    write_reg(REG_BASE_FREQ, CFG_DATA_BITS'(1));
    send_ticks(2, '0);
    // Rectangle at full gain saturates at the bottom, then silence at zero gain.
    write_reg(REG_WAVEFORM, CFG_DATA_BITS'(WAVE_RECTANGLE));
    write_reg(REG_TICK_RATE, CFG_DATA_BITS'(RST_TICK_RATE));
    write_reg(REG_BASE_FREQ, '1);
    send_ticks(2, '0);
    write_reg(REG_AMPLITUDE, '0);
    send_ticks(1, '0);
    // An undecoded register index must leave the phase running.
    write_reg(REG_SPARE_LAST, '1);
    send_ticks(1, '0);
    // Invalid waveform codes.
    write_reg(REG_AMPLITUDE, CFG_DATA_BITS'(RST_AMPLITUDE));
    write_reg(REG_WAVEFORM, CFG_DATA_BITS'(WAVE_RECTANGLE + 1));
    send_ticks(1, '0);
    write_reg(REG_WAVEFORM, CFG_DATA_BITS'(WAVE_CODE_LAST));
    send_ticks(1, '0);
    // Zero base frequency in fixed mode, then a zero tick rate.
    write_reg(REG_WAVEFORM, CFG_DATA_BITS'(WAVE_SINE));
    write_reg(REG_BASE_FREQ, '0);
    send_ticks(1, '0);
    write_reg(REG_BASE_FREQ, CFG_DATA_BITS'(RST_BASE_FREQ));
    write_reg(REG_TICK_RATE, '0);
    send_ticks(1, '0);
    // Modulation mode: a zero frequency holds the phase, the largest one wraps it.
    write_reg(REG_TICK_RATE, CFG_DATA_BITS'(RST_TICK_RATE));
    write_reg(REG_FM_ENABLE, CFG_DATA_BITS'(1));
    send_ticks(2, '0);
    send_ticks(2, '1);

    // Random part: phases of random settings, each closed once all samples are back.
    sent = 0;
    while (sent < RANDOM_TICKS) begin
      steady = ($urandom_range(0, 4) == 0);
      shuffle_config();
      n = $urandom_range(4, 40);
      for (int i = 0; i < n; i++) begin
        send_tick(rand_freq());
      end
      sent += n;
      drain();
    end

    // Anything arriving now would be an extra sample.
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (board.errors == 0) begin
      $display("waveform_oscillator_tb passed");
    end else begin
      $display("waveform_oscillator_tb failed");
    end
    $finish;
  end

endmodule

FILE: waveform_oscillator.f
rtl/wosc_pkg.sv
rtl/wosc_ctrl.sv
rtl/wosc_datapath.sv
rtl/waveform_oscillator.sv
rtl/wosc_checker.sv
tb/waveform_oscillator_tb.sv
